// ----- rtl/core/gtrav_pkg.sv -----
// Shared types and constants of the graph traversal engine.
// No dependencies; the files that use it refer to it by scoped names.
package gtrav_pkg;

  localparam int unsigned NODE_W = 5;
  localparam int unsigned ID_SPAN = 1 << NODE_W;

  typedef enum logic [1:0] {
    OP_EDGE  = 2'd0,
    OP_BFS   = 2'd1,
    OP_DFS   = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_VISITED = 2'd0,
    STAT_STORED  = 2'd1,
    STAT_DROPPED = 2'd2,
    STAT_CLEARED = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_E_RDA,
    S_E_RDB,
    S_E_WRA,
    S_E_WRB,
    S_B_INIT,
    S_B_POP,
    S_B_FRONT,
    S_B_SCAN,
    S_D_INIT,
    S_D_TOP,
    S_D_CHK,
    S_D_POP
  } state_e;

  typedef enum logic [1:0] {
    REQ_NONE,
    REQ_NODE,
    REQ_FLUSH,
    REQ_DIRECT
  } req_kind_e;

  typedef struct packed {
    req_kind_e          kind;
    status_e            status;
    logic [NODE_W-1:0]  node;
  } req_t;

endpackage

// ----- rtl/core/gtrav_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gtrav_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/core/gtrav_result.sv -----
// Result stage: holds back the latest visited node until the next one or the
// end of the walk is known, so that last can be set. Depends on gtrav_pkg.
module gtrav_result (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gtrav_pkg::req_t                req_i,
  output logic                           valid_o,
  output logic [1:0]                     status_o,
  output logic [gtrav_pkg::NODE_W-1:0]   node_o,
  output logic                           last_o
);

  logic                          pend_valid_q, pend_valid_d;
  logic [gtrav_pkg::NODE_W-1:0]  pend_node_q, pend_node_d;
  logic                          valid_q, valid_d;
  logic [1:0]                    status_q, status_d;
  logic [gtrav_pkg::NODE_W-1:0]  node_q, node_d;
  logic                          last_q, last_d;

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_node_d  = pend_node_q;
    valid_d      = 1'b0;
    status_d     = gtrav_pkg::STAT_VISITED;
    node_d       = pend_node_q;
    last_d       = 1'b0;
    unique case (req_i.kind)
      gtrav_pkg::REQ_NODE: begin
        valid_d      = pend_valid_q;
        pend_valid_d = 1'b1;
        pend_node_d  = req_i.node;
      end
      gtrav_pkg::REQ_FLUSH: begin
        valid_d      = pend_valid_q;
        last_d       = 1'b1;
        pend_valid_d = 1'b0;
      end
      gtrav_pkg::REQ_DIRECT: begin
        valid_d  = 1'b1;
        status_d = req_i.status;
        node_d   = '0;
        last_d   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      valid_q      <= 1'b0;
      status_q     <= '0;
      node_q       <= '0;
      last_q       <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      valid_q      <= valid_d;
      status_q     <= status_d;
      node_q       <= node_d;
      last_q       <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_node_q <= pend_node_d;
  end

  assign valid_o  = valid_q;
  assign status_o = status_q;
  assign node_o   = node_q;
  assign last_o   = last_q;

endmodule

// ----- rtl/core/graph_bfs_dfs_traversal_top.sv -----
// Top level of the graph traversal engine: sequencer, neighbour counts, visit
// marks, adjacency RAM and work RAM. Depends on gtrav_pkg, gtrav_ram, gtrav_result.
//
// A request is taken when start_i is high and busy_o low. A clear stays in idle;
// an add-edge reads the counts of a and b, then writes the entry of a, and of b
// too when undirected, or stops after the reads when the edge is dropped. A
// breadth-first walk pops a node, fetches it and scans its adjacency entries; a
// depth-first walk takes a step and a check state per entry and a pop state per
// backtrack, as the adjacency RAM has a registered read. Either walk opens with
// an init state and closes with a flush. Results appear on result_valid_o for
// one cycle each and cannot be held off; a visited node is shown once the next
// one is found or the walk ends, so the walk's final node carries last_o. The
// block never stalls on the receiver. Neither RAM needs clearing.
module graph_bfs_dfs_traversal_top #(
  parameter int unsigned NODES      = 32,
  parameter int unsigned MAX_DEGREE = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [1:0]                    opcode_i,
  input  logic [gtrav_pkg::NODE_W-1:0]  node_a_i,
  input  logic [gtrav_pkg::NODE_W-1:0]  node_b_i,
  input  logic                          directed_i,
  output logic                          busy_o,
  output logic                          result_valid_o,
  output logic [1:0]                    status_o,
  output logic [gtrav_pkg::NODE_W-1:0]  node_o,
  output logic                          last_o
);

  localparam int unsigned NW  = gtrav_pkg::NODE_W;
  localparam int unsigned NN  = (NODES < gtrav_pkg::ID_SPAN) ? NODES : gtrav_pkg::ID_SPAN;
  localparam int unsigned IW  = $clog2(NN);
  localparam int unsigned SPW = IW + 1;
  localparam int unsigned CW  = $clog2(MAX_DEGREE + 1);
  localparam int unsigned PW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int unsigned WW  = NW + CW;
  localparam int unsigned ADJ_DEPTH = NN * (1 << PW);

  gtrav_pkg::state_e state_q, state_d;
  gtrav_pkg::req_t   req;

  logic          accept;
  logic [NW-1:0] a_q, b_q;
  logic          dir_q;
  logic          a_in_ok, rng_ok, edge_ok;

  logic [CW-1:0] cnt_q [NN];
  logic [IW-1:0] cnt_idx;
  logic [CW-1:0] cnt_rd;
  logic          cnt_inc;
  logic [CW-1:0] cnt_a_q, cnt_a_d;

  logic [NN-1:0] mark_q;
  logic [IW-1:0] mark_idx;
  logic          mark_set, mark_clr, mark_rd;

  logic             adj_we;
  logic [IW+PW-1:0] adj_waddr, adj_raddr;
  logic [NW-1:0]    adj_wdata, adj_rdata;

  logic          work_we;
  logic [IW-1:0] work_waddr, work_raddr;
  logic [WW-1:0] work_wdata, work_rdata;

  logic [SPW-1:0] head_q, head_d, tail_q, tail_d;
  logic [NW-1:0]  f_q, f_d;
  logic [CW-1:0]  i_q, i_d;
  logic           rd_pend_q, rd_pend_d;
  logic [NW-1:0]  top_node_q, top_node_d;
  logic [CW-1:0]  top_pos_q, top_pos_d;
  logic [SPW-1:0] sp_q, sp_d, sp_m1, sp_m2;

  assign accept  = start_i && (state_q == gtrav_pkg::S_IDLE);
  assign busy_o  = (state_q != gtrav_pkg::S_IDLE);
  assign a_in_ok = 32'(node_a_i) < NN;
  assign rng_ok  = (32'(a_q) < NN) && (32'(b_q) < NN);
  assign cnt_rd  = cnt_q[cnt_idx];
  assign mark_rd = mark_q[mark_idx];
  assign sp_m1   = sp_q - SPW'(1);
  assign sp_m2   = sp_q - SPW'(2);

  always_comb begin
    if (!rng_ok) begin
      edge_ok = 1'b0;
    end else if (dir_q) begin
      edge_ok = 32'(cnt_a_q) < MAX_DEGREE;
    end else if (a_q == b_q) begin
      edge_ok = 32'(cnt_a_q) + 32'd2 <= MAX_DEGREE;
    end else begin
      edge_ok = (32'(cnt_a_q) < MAX_DEGREE) && (32'(cnt_rd) < MAX_DEGREE);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gtrav_pkg::S_IDLE: begin
        if (start_i) begin
          unique case (gtrav_pkg::opcode_e'(opcode_i))
            gtrav_pkg::OP_EDGE:  state_d = gtrav_pkg::S_E_RDA;
            gtrav_pkg::OP_BFS:   state_d = a_in_ok ? gtrav_pkg::S_B_INIT : gtrav_pkg::S_IDLE;
            gtrav_pkg::OP_DFS:   state_d = a_in_ok ? gtrav_pkg::S_D_INIT : gtrav_pkg::S_IDLE;
            gtrav_pkg::OP_CLEAR: state_d = gtrav_pkg::S_IDLE;
            default:             state_d = gtrav_pkg::S_IDLE;
          endcase
        end
      end
      gtrav_pkg::S_E_RDA: state_d = gtrav_pkg::S_E_RDB;
      gtrav_pkg::S_E_RDB: state_d = edge_ok ? gtrav_pkg::S_E_WRA : gtrav_pkg::S_IDLE;
      gtrav_pkg::S_E_WRA: state_d = dir_q ? gtrav_pkg::S_IDLE : gtrav_pkg::S_E_WRB;
      gtrav_pkg::S_E_WRB: state_d = gtrav_pkg::S_IDLE;
      gtrav_pkg::S_B_INIT: state_d = gtrav_pkg::S_B_POP;
      gtrav_pkg::S_B_POP: begin
        state_d = (head_q == tail_q) ? gtrav_pkg::S_IDLE : gtrav_pkg::S_B_FRONT;
      end
      gtrav_pkg::S_B_FRONT: state_d = gtrav_pkg::S_B_SCAN;
      gtrav_pkg::S_B_SCAN: begin
        if (!(i_q < cnt_rd)) begin
          state_d = gtrav_pkg::S_B_POP;
        end
      end
      gtrav_pkg::S_D_INIT: state_d = gtrav_pkg::S_D_TOP;
      gtrav_pkg::S_D_TOP: begin
        if (top_pos_q < cnt_rd) begin
          state_d = gtrav_pkg::S_D_CHK;
        end else if (sp_q == SPW'(1)) begin
          state_d = gtrav_pkg::S_IDLE;
        end else begin
          state_d = gtrav_pkg::S_D_POP;
        end
      end
      gtrav_pkg::S_D_CHK: state_d = gtrav_pkg::S_D_TOP;
      gtrav_pkg::S_D_POP: state_d = gtrav_pkg::S_D_TOP;
      default:            state_d = gtrav_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cnt_idx    = a_q[IW-1:0];
    cnt_inc    = 1'b0;
    cnt_a_d    = cnt_a_q;
    mark_idx   = a_q[IW-1:0];
    mark_set   = 1'b0;
    mark_clr   = 1'b0;
    adj_we     = 1'b0;
    adj_waddr  = {a_q[IW-1:0], cnt_rd[PW-1:0]};
    adj_wdata  = b_q;
    adj_raddr  = {f_q[IW-1:0], i_q[PW-1:0]};
    work_we    = 1'b0;
    work_waddr = tail_q[IW-1:0];
    work_wdata = {CW'(0), adj_rdata};
    work_raddr = head_q[IW-1:0];
    head_d     = head_q;
    tail_d     = tail_q;
    f_d        = f_q;
    i_d        = i_q;
    rd_pend_d  = rd_pend_q;
    top_node_d = top_node_q;
    top_pos_d  = top_pos_q;
    sp_d       = sp_q;
    req.kind   = gtrav_pkg::REQ_NONE;
    req.status = gtrav_pkg::STAT_VISITED;
    req.node   = '0;
    unique case (state_q)
      gtrav_pkg::S_IDLE: begin
        if (accept && (gtrav_pkg::opcode_e'(opcode_i) == gtrav_pkg::OP_CLEAR)) begin
          mark_clr   = 1'b1;
          req.kind   = gtrav_pkg::REQ_DIRECT;
          req.status = gtrav_pkg::STAT_CLEARED;
        end
      end
      gtrav_pkg::S_E_RDA: begin
        cnt_a_d = cnt_rd;
      end
      gtrav_pkg::S_E_RDB: begin
        cnt_idx = b_q[IW-1:0];
        if (!edge_ok) begin
          req.kind   = gtrav_pkg::REQ_DIRECT;
          req.status = gtrav_pkg::STAT_DROPPED;
        end
      end
      gtrav_pkg::S_E_WRA: begin
        adj_we  = 1'b1;
        cnt_inc = 1'b1;
        if (dir_q) begin
          req.kind   = gtrav_pkg::REQ_DIRECT;
          req.status = gtrav_pkg::STAT_STORED;
        end
      end
      gtrav_pkg::S_E_WRB: begin
        cnt_idx    = b_q[IW-1:0];
        adj_waddr  = {b_q[IW-1:0], cnt_rd[PW-1:0]};
        adj_wdata  = a_q;
        adj_we     = 1'b1;
        cnt_inc    = 1'b1;
        req.kind   = gtrav_pkg::REQ_DIRECT;
        req.status = gtrav_pkg::STAT_STORED;
      end
      gtrav_pkg::S_B_INIT: begin
        mark_set   = 1'b1;
        work_we    = 1'b1;
        work_waddr = '0;
        work_wdata = {CW'(0), a_q};
        head_d     = '0;
        tail_d     = SPW'(1);
      end
      gtrav_pkg::S_B_POP: begin
        if (head_q == tail_q) begin
          req.kind = gtrav_pkg::REQ_FLUSH;
        end else begin
          head_d = head_q + SPW'(1);
        end
      end
      gtrav_pkg::S_B_FRONT: begin
        f_d       = work_rdata[NW-1:0];
        i_d       = '0;
        rd_pend_d = 1'b0;
        req.kind  = gtrav_pkg::REQ_NODE;
        req.node  = work_rdata[NW-1:0];
      end
      gtrav_pkg::S_B_SCAN: begin
        cnt_idx  = f_q[IW-1:0];
        mark_idx = adj_rdata[IW-1:0];
        if (rd_pend_q && !mark_rd) begin
          mark_set = 1'b1;
          work_we  = 1'b1;
          tail_d   = tail_q + SPW'(1);
        end
        if (i_q < cnt_rd) begin
          i_d       = i_q + CW'(1);
          rd_pend_d = 1'b1;
        end else begin
          rd_pend_d = 1'b0;
        end
      end
      gtrav_pkg::S_D_INIT: begin
        mark_set   = 1'b1;
        req.kind   = gtrav_pkg::REQ_NODE;
        req.node   = a_q;
        top_node_d = a_q;
        top_pos_d  = '0;
        sp_d       = SPW'(1);
      end
      gtrav_pkg::S_D_TOP: begin
        cnt_idx    = top_node_q[IW-1:0];
        adj_raddr  = {top_node_q[IW-1:0], top_pos_q[PW-1:0]};
        work_raddr = sp_m2[IW-1:0];
        if (top_pos_q < cnt_rd) begin
          top_pos_d = top_pos_q + CW'(1);
        end else if (sp_q == SPW'(1)) begin
          req.kind = gtrav_pkg::REQ_FLUSH;
        end else begin
          sp_d = sp_m1;
        end
      end
      gtrav_pkg::S_D_CHK: begin
        mark_idx   = adj_rdata[IW-1:0];
        work_waddr = sp_m1[IW-1:0];
        work_wdata = {top_pos_q, top_node_q};
        if (!mark_rd) begin
          mark_set   = 1'b1;
          work_we    = 1'b1;
          req.kind   = gtrav_pkg::REQ_NODE;
          req.node   = adj_rdata;
          top_node_d = adj_rdata;
          top_pos_d  = '0;
          sp_d       = sp_q + SPW'(1);
        end
      end
      gtrav_pkg::S_D_POP: begin
        top_node_d = work_rdata[NW-1:0];
        top_pos_d  = work_rdata[WW-1:NW];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gtrav_pkg::S_IDLE;
      for (int k = 0; k < NN; k++) begin
        cnt_q[k] <= '0;
      end
      mark_q <= '0;
    end else begin
      state_q <= state_d;
      if (cnt_inc) begin
        cnt_q[cnt_idx] <= cnt_rd + CW'(1);
      end
      if (mark_clr) begin
        mark_q <= '0;
      end else if (mark_set) begin
        mark_q[mark_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q   <= node_a_i;
      b_q   <= node_b_i;
      dir_q <= directed_i;
    end
    cnt_a_q    <= cnt_a_d;
    head_q     <= head_d;
    tail_q     <= tail_d;
    f_q        <= f_d;
    i_q        <= i_d;
    rd_pend_q  <= rd_pend_d;
    top_node_q <= top_node_d;
    top_pos_q  <= top_pos_d;
    sp_q       <= sp_d;
  end

  gtrav_ram #(
    .WIDTH (NW),
    .DEPTH (ADJ_DEPTH)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  gtrav_ram #(
    .WIDTH (WW),
    .DEPTH (NN)
  ) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (work_we),
    .waddr_i (work_waddr),
    .wdata_i (work_wdata),
    .raddr_i (work_raddr),
    .rdata_o (work_rdata)
  );

  gtrav_result u_result (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .valid_o  (result_valid_o),
    .status_o (status_o),
    .node_o   (node_o),
    .last_o   (last_o)
  );

endmodule

// ----- rtl/core/gtrav_checker.sv -----
// Port-level checks of the traversal engine and their bind to the top level.
// Depends on gtrav_pkg and graph_bfs_dfs_traversal_top.
module gtrav_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic [1:0]                    opcode_i,
  input logic                          busy_o,
  input logic                          result_valid_o,
  input logic [1:0]                    status_o,
  input logic [gtrav_pkg::NODE_W-1:0]  node_o,
  input logic                          last_o
);

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != gtrav_pkg::STAT_VISITED) |-> last_o && (node_o == '0))
    else $error("non-node result without last or with a node id");

  a_clear_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (opcode_i == gtrav_pkg::OP_CLEAR)
    |=> result_valid_o && (status_o == gtrav_pkg::STAT_CLEARED) && last_o)
    else $error("clear request not answered in the next cycle");

  a_mid_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy_o)
    else $error("intermediate result while idle");

  a_edge_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (opcode_i == gtrav_pkg::OP_EDGE) |=> busy_o && !result_valid_o)
    else $error("edge request not taken up");

endmodule

bind graph_bfs_dfs_traversal_top gtrav_checker u_gtrav_checker (.*);
